// ----- rtl/core/dspjc_pkg.sv -----
// Shared types and constants for the dual-axis servo PWM jog controller.
`timescale 1ns / 1ps

package dspjc_pkg;

  localparam int COUNT_BITS = 12;
  localparam int REG_W      = 12;
  localparam int CMP_W      = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
  localparam int CMD_W      = 8;
  localparam int CFG_IDX_W  = 3;

  localparam logic [REG_W-1:0] PERIOD_RST = REG_W'(300);
  localparam logic [REG_W-1:0] X_LO_RST   = REG_W'(6);
  localparam logic [REG_W-1:0] X_HI_RST   = REG_W'(37);
  localparam logic [REG_W-1:0] Y_LO_RST   = REG_W'(6);
  localparam logic [REG_W-1:0] Y_HI_RST   = REG_W'(20);
  localparam logic [REG_W-1:0] X_W_RST    = REG_W'(21);
  localparam logic [REG_W-1:0] Y_W_RST    = REG_W'(6);

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  localparam logic [CMD_W-1:0] CMD_E1 = 8'hE1;
  localparam logic [CMD_W-1:0] CMD_E2 = 8'hE2;
  localparam logic [CMD_W-1:0] CMD_E3 = 8'hE3;
  localparam logic [CMD_W-1:0] CMD_E4 = 8'hE4;
  localparam logic [CMD_W-1:0] CMD_E5 = 8'hE5;
  localparam logic [CMD_W-1:0] CMD_E6 = 8'hE6;
  localparam logic [CMD_W-1:0] CMD_E7 = 8'hE7;
  localparam logic [CMD_W-1:0] CMD_E8 = 8'hE8;
  localparam logic [CMD_W-1:0] CMD_E9 = 8'hE9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 3'd0,
    REG_X_LO   = 3'd1,
    REG_X_HI   = 3'd2,
    REG_Y_LO   = 3'd3,
    REG_Y_HI   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [REG_W-1:0] period;
    logic [REG_W-1:0] x_lo;
    logic [REG_W-1:0] x_hi;
    logic [REG_W-1:0] y_lo;
    logic [REG_W-1:0] y_hi;
  } cfg_t;

  typedef struct packed {
    logic x_dn;
    logic x_up;
    logic y_dn;
    logic y_up;
    logic echo;
  } jog_t;

  typedef struct packed {
    logic             pwm_x;
    logic             pwm_y;
    logic             echo_valid;
    logic [CMD_W-1:0] echo_byte;
    logic [REG_W-1:0] x_width;
    logic [REG_W-1:0] y_width;
  } result_t;

endpackage

// ----- rtl/core/dspjc_cfg_regs.sv -----
// Configuration register file: period and pulse width limits.
`timescale 1ns / 1ps

module dspjc_cfg_regs
  import dspjc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_idx,
  input  logic [REG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        REG_PERIOD: cfg_nxt.period = wr_data;
        REG_X_LO:   cfg_nxt.x_lo   = wr_data;
        REG_X_HI:   cfg_nxt.x_hi   = wr_data;
        REG_Y_LO:   cfg_nxt.y_lo   = wr_data;
        REG_Y_HI:   cfg_nxt.y_hi   = wr_data;
        default:    cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period <= PERIOD_RST;
      cfg_r.x_lo   <= X_LO_RST;
      cfg_r.x_hi   <= X_HI_RST;
      cfg_r.y_lo   <= Y_LO_RST;
      cfg_r.y_hi   <= Y_HI_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/dspjc_cmd_decode.sv -----
// Command byte decoder: jog directions for both axes and echo request.
`timescale 1ns / 1ps

module dspjc_cmd_decode
  import dspjc_pkg::*;
(
  input  logic [CMD_W-1:0] cmd,
  output jog_t             jog
);

  always_comb begin
    jog = '0;
    unique case (cmd) inside
      CMD_E1, CMD_E4, CMD_E7: jog.x_dn = 1'b1;
      CMD_E3, CMD_E6, CMD_E9: jog.x_up = 1'b1;
      default:                jog.x_dn = 1'b0;
    endcase
    unique case (cmd) inside
      CMD_E1, CMD_E2, CMD_E3: jog.y_up = 1'b1;
      CMD_E7, CMD_E8, CMD_E9: jog.y_dn = 1'b1;
      default:                jog.y_up = 1'b0;
    endcase
    jog.echo = (cmd == CMD_E1);
  end

endmodule

// ----- rtl/core/dspjc_datapath.sv -----
// Period counter, pulse width jog and PWM level state with next-result logic.
`timescale 1ns / 1ps

module dspjc_datapath
  import dspjc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             kind,
  input  logic [CMD_W-1:0] cmd,
  input  jog_t             jog,
  input  cfg_t             cfg,
  output result_t          res
);

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [REG_W-1:0]      x_w_r, x_w_nxt;
  logic [REG_W-1:0]      y_w_r, y_w_nxt;
  logic                  pwm_x_r, pwm_x_nxt;
  logic                  pwm_y_r, pwm_y_nxt;
  logic                  is_tick;

  assign is_tick = (kind == KIND_TICK);
  assign cnt_inc = cnt_r + COUNT_BITS'(1);

  always_comb begin
    cnt_nxt   = cnt_r;
    x_w_nxt   = x_w_r;
    y_w_nxt   = y_w_r;
    pwm_x_nxt = pwm_x_r;
    pwm_y_nxt = pwm_y_r;
    if (is_tick) begin
      cnt_nxt   = (CMP_W'(cnt_inc) >= CMP_W'(cfg.period)) ? '0 : cnt_inc;
      pwm_x_nxt = (CMP_W'(cnt_nxt) <= CMP_W'(x_w_r));
      pwm_y_nxt = (CMP_W'(cnt_nxt) <= CMP_W'(y_w_r));
    end else begin
      if (jog.x_dn && (x_w_r > cfg.x_lo)) begin
        x_w_nxt = x_w_r - REG_W'(1);
      end else if (jog.x_up && (x_w_r < cfg.x_hi)) begin
        x_w_nxt = x_w_r + REG_W'(1);
      end
      if (jog.y_dn && (y_w_r > cfg.y_lo)) begin
        y_w_nxt = y_w_r - REG_W'(1);
      end else if (jog.y_up && (y_w_r < cfg.y_hi)) begin
        y_w_nxt = y_w_r + REG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      x_w_r   <= X_W_RST;
      y_w_r   <= Y_W_RST;
      pwm_x_r <= 1'b1;
      pwm_y_r <= 1'b1;
    end else if (accept) begin
      cnt_r   <= cnt_nxt;
      x_w_r   <= x_w_nxt;
      y_w_r   <= y_w_nxt;
      pwm_x_r <= pwm_x_nxt;
      pwm_y_r <= pwm_y_nxt;
    end
  end

  always_comb begin
    res.pwm_x      = pwm_x_nxt;
    res.pwm_y      = pwm_y_nxt;
    res.echo_valid = !is_tick && jog.echo;
    res.echo_byte  = (!is_tick && jog.echo) ? cmd : '0;
    res.x_width    = x_w_nxt;
    res.y_width    = y_w_nxt;
  end

  a_tick_holds_widths: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_tick |=> $stable(x_w_r) && $stable(y_w_r))
    else $error("pulse width moved on a tick transaction");

  a_cmd_holds_counter: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_tick |=> $stable(cnt_r) && $stable(pwm_x_r) && $stable(pwm_y_r))
    else $error("counter or PWM level moved on a command transaction");

  a_counter_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_tick |=> (cnt_r == '0) || (CMP_W'(cnt_r) < CMP_W'($past(cfg.period))))
    else $error("period counter not wrapped at period");

endmodule

// ----- rtl/core/dual_servo_pwm_jog_controller_core.sv -----
// Top level of the dual-axis servo PWM jog controller.
`timescale 1ns / 1ps

// Takes one transaction per clock: a tick (kind 0) advances the period counter and
// refreshes both PWM levels, a command byte (kind 1, codes 0xE1 to 0xE9) jogs the x and
// y pulse widths by one step within the configured limits. Every input transaction
// yields exactly one result in the next cycle, held in an output register; the input
// stalls only while that register is full and the result side stalls. Configuration
// writes are always ready and must be issued while no transaction is in flight.

module dual_servo_pwm_jog_controller_core
  import dspjc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [CMD_W-1:0]     in_command_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_pwm_x,
  output logic                 out_pwm_y,
  output logic                 out_echo_valid,
  output logic [CMD_W-1:0]     out_echo_byte,
  output logic [REG_W-1:0]     out_x_width,
  output logic [REG_W-1:0]     out_y_width,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  cfg_t    cfg;
  jog_t    jog;
  result_t res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  dspjc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  dspjc_cmd_decode u_dec (
    .cmd (in_command_byte),
    .jog (jog)
  );

  dspjc_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .kind   (in_kind),
    .cmd    (in_command_byte),
    .jog    (jog),
    .cfg    (cfg),
    .res    (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pwm_x      = res_r.pwm_x;
  assign out_pwm_y      = res_r.pwm_y;
  assign out_echo_valid = res_r.echo_valid;
  assign out_echo_byte  = res_r.echo_byte;
  assign out_x_width    = res_r.x_width;
  assign out_y_width    = res_r.y_width;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_echo_byte_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_echo_valid |-> out_echo_byte == CMD_E1)
    else $error("echo byte differs from echo command");

  a_tick_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_kind == KIND_TICK) |=> !out_echo_valid && (out_echo_byte == '0))
    else $error("echo raised on a tick transaction");

endmodule
